// File: rtl/fsvg_pkg.sv
// Shared constants, types and tables for the fan sector vertex generator.
// No dependencies; every other file imports this package.
package fsvg_pkg;

  localparam int SEGMENTS      = 100;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 24;
  localparam int NSTAGES       = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int STG_W         = $clog2(MAX_STAGES);

  // Port field widths.
  localparam int IDX_W   = 7;
  localparam int RAD_W   = 16;
  localparam int ANG_W   = 18;
  localparam int COORD_W = 17;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef enum logic [ADDR_W-3:0] {
    REG_RADIUS = 2'd0,
    REG_START  = 2'd1,
    REG_END    = 2'd2
  } fsvg_reg_t;

  // Arc offset: round(span * (k-1) / SEGMENTS) = (2*prod + SEGMENTS) / (2*SEGMENTS),
  // done as a multiply by a rounded-up reciprocal.
  localparam int PROD_W  = ANG_W + IDX_W;
  localparam int NUM_W   = PROD_W + 2;
  localparam int OFF_DIV = 2 * SEGMENTS;
  localparam int SH1     = NUM_W + $clog2(OFF_DIV);
  localparam int M1_W    = NUM_W + 1;
  localparam logic [M1_W-1:0] M1 = M1_W'(((64'd1 << SH1) + OFF_DIV - 1) / OFF_DIV);
  localparam int OFF_W   = NUM_W - $clog2(OFF_DIV) + 1;

  // Angle units: 92160 per turn. The bias adds two turns and removes a quarter turn,
  // which keeps the sum positive.
  localparam int TURN_UNITS    = 92160;
  localparam int QUARTER_UNITS = 23040;
  localparam int ANGLE_BIAS    = 2 * TURN_UNITS - QUARTER_UNITS;
  localparam int V_W           = OFF_W + 2;

  // One turn is 1024 steps of 90 units; each step is 2^22 binary angle units.
  localparam int BIN_DIV   = 90;
  localparam int TURN_BITS = 10;
  localparam int FRAC_BITS = 22;
  localparam int RA_W      = $clog2(BIN_DIV);
  localparam int SH2       = V_W + RA_W;
  localparam int M2_W      = V_W + 1;
  localparam logic [M2_W-1:0] M2 = M2_W'(((64'd1 << SH2) + BIN_DIV - 1) / BIN_DIV);
  localparam int Q_W       = V_W - RA_W + 1;

  typedef logic [FRAC_BITS-1:0] ang_frac_tab_t [BIN_DIV];

  function automatic ang_frac_tab_t gen_ang_frac();
    ang_frac_tab_t tab;
    for (int i = 0; i < BIN_DIV; i++) begin
      tab[i] = FRAC_BITS'(((64'(i) << FRAC_BITS) + 45) / 90);
    end
    return tab;
  endfunction

  // Rounded binary angle of the remainder within one 90-unit step.
  localparam ang_frac_tab_t ANG_TAB = gen_ang_frac();

  // CORDIC datapath: x and y in Q30, z in binary angle units.
  localparam int XY_W = 33;
  localparam int Z_W  = 33;
  localparam logic signed [XY_W-1:0] GAIN = XY_W'(652032874);

  localparam logic [29:0] ATAN_TAB [MAX_STAGES] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  // Scaling of the unit vector by the radius.
  localparam int P_W       = RAD_W + 1 + XY_W;
  localparam int FRAC_Q    = 30;
  localparam int ROUND_BIT = 29;

  typedef struct packed {
    logic [RAD_W-1:0]        radius;
    logic signed [ANG_W-1:0] angle_a;
    logic signed [ANG_W-1:0] angle_b;
  } fsvg_cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   center;
    logic                   neg;
  } fsvg_cd_t;

endpackage

// File: rtl/fsvg_if.sv
// Valid/ready channel interfaces for the vertex index input and the vertex output.
// Depends on fsvg_pkg for field widths.
interface fsvg_idx_if import fsvg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] vertex_index;

  modport source (output valid, vertex_index, input ready);
  modport sink (input valid, vertex_index, output ready);
endinterface

interface fsvg_vtx_if import fsvg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;

  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

// File: rtl/fsvg_cfg.sv
// APB-style register file holding radius and the two sector angles.
// Depends on fsvg_pkg.
module fsvg_cfg import fsvg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output fsvg_cfg_t         cfg
);

  logic      wr;
  fsvg_reg_t sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = fsvg_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (sel)
        REG_RADIUS: cfg.radius  <= pwdata[RAD_W-1:0];
        REG_START:  cfg.angle_a <= pwdata[ANG_W-1:0];
        REG_END:    cfg.angle_b <= pwdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_RADIUS: prdata = DATA_W'(cfg.radius);
      REG_START:  prdata = DATA_W'(unsigned'(cfg.angle_a));
      REG_END:    prdata = DATA_W'(unsigned'(cfg.angle_b));
      default:    prdata = '0;
    endcase
  end

endmodule

// File: rtl/fsvg_angle.sv
// Front end: turns a vertex index into the CORDIC start word (binary angle, quadrant fold).
// Five register stages. Depends on fsvg_pkg.
module fsvg_angle import fsvg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             take,
  input  logic [IDX_W-1:0] vertex_index,
  input  fsvg_cfg_t        cfg,
  output logic             valid_out,
  output fsvg_cd_t         d_out
);

  logic signed [ANG_W-1:0]  lo, hi;
  logic [ANG_W-1:0]         span;

  logic                     v1, v2, v3, v4;
  logic [IDX_W-1:0]         k1;
  logic                     c2, c3, c4;
  logic [PROD_W-1:0]        prod2;
  logic [OFF_W-1:0]         off3;
  logic [V_W-1:0]           vv4;
  logic [Q_W-1:0]           q4;

  logic [NUM_W-1:0]         num;
  logic [NUM_W+M1_W-1:0]    full1;
  logic [V_W-1:0]           vsum;
  logic [V_W+M2_W-1:0]      full2;
  logic [V_W-1:0]           rem;
  logic [RA_W-1:0]          ra;
  logic [31:0]              t;
  logic                     quad;

  // The smaller angle is the start; the span is always non-negative.
  always_comb begin
    lo   = (cfg.angle_a < cfg.angle_b) ? cfg.angle_a : cfg.angle_b;
    hi   = (cfg.angle_a < cfg.angle_b) ? cfg.angle_b : cfg.angle_a;
    span = ANG_W'(hi - lo);
  end

  always_comb begin
    num   = {prod2, 1'b0} + NUM_W'(SEGMENTS);
    full1 = (NUM_W+M1_W)'(num) * (NUM_W+M1_W)'(M1);
    vsum  = V_W'(lo) + V_W'(off3) + V_W'(ANGLE_BIAS);
    full2 = (V_W+M2_W)'(vsum) * (V_W+M2_W)'(M2);
    rem   = vv4 - V_W'(q4) * V_W'(BIN_DIV);
    ra    = rem[RA_W-1:0];
    // The turn wraps for free: only the low quotient bits reach the binary angle.
    t     = {q4[TURN_BITS-1:0], ANG_TAB[ra]};
    quad  = t[31] ^ t[30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1        <= take;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      valid_out <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1           <= vertex_index;
      c2           <= (k1 == '0);
      prod2        <= PROD_W'(span) * PROD_W'(k1 - IDX_W'(1));
      c3           <= c2;
      off3         <= full1[SH1 +: OFF_W];
      c4           <= c3;
      vv4          <= vsum;
      q4           <= full2[SH2 +: Q_W];
      d_out.x      <= GAIN;
      d_out.y      <= '0;
      // Angles in the left half plane are turned by half a turn and negated later.
      d_out.z      <= Z_W'($signed({t[31] ^ quad, t[30:0]}));
      d_out.center <= c4;
      d_out.neg    <= quad;
    end
  end

endmodule

// File: rtl/fsvg_cell.sv
// One CORDIC rotation cell: a single micro-rotation with its own register stage.
// Depends on fsvg_pkg.
module fsvg_cell import fsvg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [STG_W-1:0] stage,
  input  logic             valid_in,
  input  fsvg_cd_t         d_in,
  output logic             valid_out,
  output fsvg_cd_t         d_out
);

  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  atn;
  logic                   rot;

  always_comb begin
    xs  = $signed(d_in.x) >>> stage;
    ys  = $signed(d_in.y) >>> stage;
    atn = $signed(Z_W'(ATAN_TAB[stage]));
    rot = ~d_in.z[Z_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.x      <= rot ? $signed(d_in.x) - ys : $signed(d_in.x) + ys;
      d_out.y      <= rot ? $signed(d_in.y) + xs : $signed(d_in.y) - xs;
      d_out.z      <= rot ? $signed(d_in.z) - atn : $signed(d_in.z) + atn;
      d_out.center <= d_in.center;
      d_out.neg    <= d_in.neg;
    end
  end

endmodule

// File: rtl/fsvg_scale.sv
// Back end: scales the rotated unit vector by the radius, rounds, offsets by r and clamps.
// One multiply stage; the placement logic is combinational. Depends on fsvg_pkg.
module fsvg_scale import fsvg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  fsvg_cd_t           d_in,
  input  logic [RAD_W-1:0]   radius,
  output logic               valid_out,
  output logic [COORD_W-1:0] x_coord,
  output logic [COORD_W-1:0] y_coord
);

  localparam int SH_W = P_W - FRAC_Q;
  localparam logic signed [P_W-1:0] HALF = P_W'(1) << ROUND_BIT;

  logic signed [XY_W-1:0]  xn, yn;
  logic signed [RAD_W:0]   rs;
  logic signed [P_W-1:0]   px, py;
  logic                    center;

  function automatic logic [COORD_W-1:0] place_coord(input logic [RAD_W-1:0] r,
                                                     input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] rnd;
    logic signed [SH_W:0]  v;
    logic [COORD_W-1:0]    lim;
    rnd = (p + HALF) >>> FRAC_Q;
    v   = $signed(rnd[SH_W:0]) + $signed({{(SH_W+1-RAD_W){1'b0}}, r});
    lim = {r, 1'b0};
    if (v[SH_W]) begin
      return '0;
    end else if (v[SH_W-1:0] > (SH_W)'(lim)) begin
      return lim;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

  always_comb begin
    xn = d_in.neg ? -$signed(d_in.x) : $signed(d_in.x);
    yn = d_in.neg ? -$signed(d_in.y) : $signed(d_in.y);
    rs = $signed({1'b0, radius});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px     <= P_W'(rs) * P_W'(xn);
      py     <= P_W'(rs) * P_W'(yn);
      center <= d_in.center;
    end
  end

  always_comb begin
    if (center) begin
      x_coord = COORD_W'(radius);
      y_coord = COORD_W'(radius);
    end else begin
      x_coord = place_coord(radius, px);
      y_coord = place_coord(radius, py);
    end
  end

endmodule

// File: rtl/fan_sector_vertex_generator_top.sv
// Top level of the fan sector vertex generator: registers, angle front end, CORDIC
// cell chain, scaler and output buffer. Depends on fsvg_pkg, fsvg_if and all fsvg modules.
//
// Each accepted vertex index yields one vertex word. Index 0 gives the center (r, r);
// index k gives the arc point at lo + (hi - lo) * (k - 1) / 100 minus a quarter turn,
// where lo and hi are the smaller and larger configured angles. A new index is taken
// every clock cycle while ready is high; an accepted index passes through five angle
// stages, one cell per CORDIC iteration for 16 cells, a multiply stage and
// the output register. A two-entry output buffer lets the pipeline keep accepting while
// one finished word waits; ready drops only when both entries are full. Registers are
// written over the APB port and must only change while no vertex is in flight.
module fan_sector_vertex_generator_top import fsvg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fsvg_idx_if.sink          idx_ch,
  fsvg_vtx_if.source        vtx_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  fsvg_cfg_t          cfg;
  logic               en;
  logic               take;
  fsvg_cd_t           cd [NSTAGES+1];
  logic               cv [NSTAGES+1];
  logic               pv;
  logic [COORD_W-1:0] px, py;
  logic               ov, sv;
  logic [COORD_W-1:0] ox, oy, sx, sy;

  // The whole pipeline moves unless the skid entry is occupied.
  assign en           = ~sv;
  assign idx_ch.ready = en;
  assign take         = idx_ch.valid & en;

  fsvg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fsvg_angle u_angle (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .take         (take),
    .vertex_index (idx_ch.vertex_index),
    .cfg          (cfg),
    .valid_out    (cv[0]),
    .d_out        (cd[0])
  );

  for (genvar g = 0; g < NSTAGES; g++) begin : g_cell
    fsvg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .stage     (STG_W'(g)),
      .valid_in  (cv[g]),
      .d_in      (cd[g]),
      .valid_out (cv[g+1]),
      .d_out     (cd[g+1])
    );
  end

  fsvg_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (cv[NSTAGES]),
    .d_in      (cd[NSTAGES]),
    .radius    (cfg.radius),
    .valid_out (pv),
    .x_coord   (px),
    .y_coord   (py)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (vtx_ch.ready) begin
        sv <= 1'b0;
      end
    end else if (pv) begin
      if (ov && !vtx_ch.ready) begin
        sv <= 1'b1;
      end else begin
        ov <= 1'b1;
      end
    end else if (vtx_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (vtx_ch.ready) begin
        ox <= sx;
        oy <= sy;
      end
    end else if (pv) begin
      if (ov && !vtx_ch.ready) begin
        sx <= px;
        sy <= py;
      end else begin
        ox <= px;
        oy <= py;
      end
    end
  end

  assign vtx_ch.valid   = ov;
  assign vtx_ch.x_coord = ox;
  assign vtx_ch.y_coord = oy;

  // The skid entry only fills behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry valid without an output word");

  // Input ready falls only after a finished word met a stalled output.
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
      $fell(idx_ch.ready) |-> $past(pv && ov && !vtx_ch.ready))
    else $error("input ready dropped without an output stall");

  // After the quadrant fold the CORDIC start angle lies within a quarter turn of zero.
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
      cv[0] |-> (cd[0].z[Z_W-1:Z_W-3] == 3'b000 || cd[0].z[Z_W-1:Z_W-3] == 3'b111))
    else $error("CORDIC start angle outside the folded range");

endmodule
